// ===== sv/rhc_pkg.sv =====
// Shared types and constants for the RGB to HSV converter.
// Used by every module of the block; depends on nothing else.
package rhc_pkg;

  localparam int unsigned ChanW  = 8;
  localparam int unsigned PixW   = 3 * ChanW;
  localparam int unsigned HueW   = 15;
  localparam int unsigned SatW   = 16;
  localparam int unsigned QuotW  = 16;
  localparam int unsigned NumCells = QuotW;

  localparam logic [HueW-1:0] HueBaseRed   = 15'd0;
  localparam logic [HueW-1:0] HueBaseGreen = 15'd7680;
  localparam logic [HueW-1:0] HueBaseBlue  = 15'd15360;
  localparam logic [HueW-1:0] HueFull      = 15'd23040;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // Word handed from cell to cell: both dividers in flight for one pixel.
  typedef struct packed {
    logic [ChanW-1:0] vmax;
    logic [ChanW-1:0] delta;
    logic [ChanW-1:0] rem_s;
    logic [ChanW-1:0] rem_h;
    logic [QuotW-1:0] num_s;
    logic [QuotW-1:0] num_h;
    logic [QuotW-1:0] q_s;
    logic [QuotW-1:0] q_h;
    sector_t          sector;
    logic             neg;
    logic             hue_zero;
    logic             sat_zero;
  } div_word_t;

endpackage

// ===== sv/rhc_front.sv =====
// Input stage: unpacks the pixel, finds max, min, sector and the hue numerator.
// Depends on rhc_pkg.
module rhc_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [rhc_pkg::PixW-1:0] in_rgb_pixel,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output rhc_pkg::div_word_t       dn_word
);

  logic                       valid_r;
  rhc_pkg::div_word_t         word_r;
  rhc_pkg::div_word_t         word_nxt;
  logic [rhc_pkg::ChanW-1:0]  red;
  logic [rhc_pkg::ChanW-1:0]  grn;
  logic [rhc_pkg::ChanW-1:0]  blu;
  logic [rhc_pkg::ChanW-1:0]  vmax;
  logic [rhc_pkg::ChanW-1:0]  vmin;
  logic [rhc_pkg::ChanW-1:0]  delta;
  logic [rhc_pkg::ChanW:0]    diff;
  logic [rhc_pkg::ChanW-1:0]  diff_abs;
  logic [11:0]                hue_num;
  rhc_pkg::sector_t           sector;

  assign red = in_rgb_pixel[23:16];
  assign grn = in_rgb_pixel[15:8];
  assign blu = in_rgb_pixel[7:0];

  always_comb begin
    if (red >= grn && red >= blu) begin
      sector = rhc_pkg::SECT_RED;
      vmax   = red;
      diff   = {1'b0, grn} - {1'b0, blu};
    end else if (grn >= blu) begin
      sector = rhc_pkg::SECT_GREEN;
      vmax   = grn;
      diff   = {1'b0, blu} - {1'b0, red};
    end else begin
      sector = rhc_pkg::SECT_BLUE;
      vmax   = blu;
      diff   = {1'b0, red} - {1'b0, grn};
    end
    if (red <= grn && red <= blu) begin
      vmin = red;
    end else if (grn <= blu) begin
      vmin = grn;
    end else begin
      vmin = blu;
    end
    delta    = vmax - vmin;
    diff_abs = diff[8] ? 8'(~diff + 9'd1) : diff[7:0];
    // |diff| * 15; the remaining factor of 256 comes from the zero bits below.
    hue_num  = {diff_abs, 4'b0000} - {4'b0000, diff_abs};

    // Start each division part way in: the leading remainder is already below
    // its divisor, so only sixteen quotient bits remain to be found.
    word_nxt.vmax     = vmax;
    word_nxt.delta    = delta;
    word_nxt.rem_s    = {1'b0, delta[7:1]};
    word_nxt.num_s    = {delta[0], 15'd0};
    word_nxt.rem_h    = {4'b0000, hue_num[11:8]};
    word_nxt.num_h    = {hue_num[7:0], 8'd0};
    word_nxt.q_s      = '0;
    word_nxt.q_h      = '0;
    word_nxt.sector   = sector;
    word_nxt.neg      = diff[8];
    word_nxt.hue_zero = (delta == 8'd0);
    word_nxt.sat_zero = (vmax == 8'd0);
  end

  assign in_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

// ===== sv/rhc_div_cell.sv =====
// One cell of the divider chain: a restoring step for saturation and for hue.
// Depends on rhc_pkg.
module rhc_div_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               up_valid,
  output logic               up_ready,
  input  rhc_pkg::div_word_t up_word,
  output logic               dn_valid,
  input  logic               dn_ready,
  output rhc_pkg::div_word_t dn_word
);

  logic                      valid_r;
  rhc_pkg::div_word_t        word_r;
  rhc_pkg::div_word_t        word_nxt;
  logic [rhc_pkg::ChanW:0]   trial_s;
  logic [rhc_pkg::ChanW:0]   trial_h;
  logic [rhc_pkg::ChanW:0]   left_s;
  logic [rhc_pkg::ChanW:0]   left_h;
  logic                      fit_s;
  logic                      fit_h;

  always_comb begin
    trial_s = {up_word.rem_s, up_word.num_s[rhc_pkg::QuotW-1]};
    trial_h = {up_word.rem_h, up_word.num_h[rhc_pkg::QuotW-1]};
    fit_s   = trial_s >= {1'b0, up_word.vmax};
    fit_h   = trial_h >= {1'b0, up_word.delta};
    left_s  = fit_s ? trial_s - {1'b0, up_word.vmax}  : trial_s;
    left_h  = fit_h ? trial_h - {1'b0, up_word.delta} : trial_h;

    word_nxt       = up_word;
    word_nxt.rem_s = left_s[rhc_pkg::ChanW-1:0];
    word_nxt.rem_h = left_h[rhc_pkg::ChanW-1:0];
    word_nxt.num_s = {up_word.num_s[rhc_pkg::QuotW-2:0], 1'b0};
    word_nxt.num_h = {up_word.num_h[rhc_pkg::QuotW-2:0], 1'b0};
    word_nxt.q_s   = {up_word.q_s[rhc_pkg::QuotW-2:0], fit_s};
    word_nxt.q_h   = {up_word.q_h[rhc_pkg::QuotW-2:0], fit_h};
  end

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      word_r <= word_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_word  = word_r;

endmodule

// ===== sv/rhc_back.sv =====
// Output stage: adds the sector base, wraps negative hue, applies the grey
// and black cases and holds the result beat. Depends on rhc_pkg.
module rhc_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  rhc_pkg::div_word_t       up_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [rhc_pkg::HueW-1:0] out_hue,
  output logic [rhc_pkg::SatW-1:0] out_saturation,
  output logic [rhc_pkg::ChanW-1:0] out_value
);

  logic                       valid_r;
  logic [rhc_pkg::HueW-1:0]   hue_r;
  logic [rhc_pkg::SatW-1:0]   sat_r;
  logic [rhc_pkg::ChanW-1:0]  value_r;
  logic [rhc_pkg::HueW-1:0]   hue_nxt;
  logic [rhc_pkg::SatW-1:0]   sat_nxt;
  logic [rhc_pkg::HueW-1:0]   base;
  logic signed [rhc_pkg::HueW:0] hue_sum;
  logic signed [rhc_pkg::HueW:0] hue_wrap;
  logic signed [rhc_pkg::HueW:0] quot;

  always_comb begin
    case (up_word.sector)
      rhc_pkg::SECT_RED:   base = rhc_pkg::HueBaseRed;
      rhc_pkg::SECT_GREEN: base = rhc_pkg::HueBaseGreen;
      rhc_pkg::SECT_BLUE:  base = rhc_pkg::HueBaseBlue;
      default:             base = rhc_pkg::HueBaseRed;
    endcase
    quot     = signed'({4'b0000, up_word.q_h[11:0]});
    hue_sum  = signed'({1'b0, base}) + (up_word.neg ? -quot : quot);
    hue_wrap = hue_sum[rhc_pkg::HueW] ? hue_sum + signed'({1'b0, rhc_pkg::HueFull})
                                      : hue_sum;
    hue_nxt  = up_word.hue_zero ? '0 : hue_wrap[rhc_pkg::HueW-1:0];
    sat_nxt  = up_word.sat_zero ? '0 : up_word.q_s;
  end

  assign up_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      value_r <= up_word.vmax;
    end
  end

  assign out_valid      = valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_value      = value_r;

endmodule

// ===== sv/rgb_to_hsv_convert.sv =====
// Top level of the RGB to HSV converter: input stage, divider cell chain and
// output stage. Depends on rhc_pkg, rhc_front, rhc_div_cell and rhc_back.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid / in_ready    in_rgb_pixel[23:0]
//   out      output     out_valid / out_ready  out_hue[14:0], out_saturation[15:0],
//                                              out_value[7:0]
//
// One pixel beat is taken every cycle when the output side keeps up; each
// beat passes in turn through one input stage, sixteen divider cells
// and one output register.
// Reset (rst_n low at a clock edge) empties every stage; payload registers
// keep whatever they held.
// A stall at the output holds only those stages that are full: each stage
// takes a new beat whenever it is empty or its neighbour downstream moves.
//
// Saturation is delta * 32768 / max and hue is a sector base plus or minus
// |diff| * 3840 / delta. Both quotients are found together, one bit per cell, by
// restoring division: each cell compares a nine-bit trial remainder with
// the divisor, subtracts where it fits and shifts the next numerator bit in.
// The pixel's max, delta, sector and flags travel with it down the chain.
// The grey case (delta zero) forces hue to 0 and the black case (max zero)
// forces saturation to 0, which covers the divisions by zero.
module rgb_to_hsv_convert (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rhc_pkg::PixW-1:0]  in_rgb_pixel,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [rhc_pkg::HueW-1:0]  out_hue,
  output logic [rhc_pkg::SatW-1:0]  out_saturation,
  output logic [rhc_pkg::ChanW-1:0] out_value
);

  // Link k joins cell k-1 (or the input stage) to cell k (or the output stage).
  logic               link_valid [rhc_pkg::NumCells+1];
  logic               link_ready [rhc_pkg::NumCells+1];
  rhc_pkg::div_word_t link_word  [rhc_pkg::NumCells+1];

  rhc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_rgb_pixel (in_rgb_pixel),
    .dn_valid     (link_valid[0]),
    .dn_ready     (link_ready[0]),
    .dn_word      (link_word[0])
  );

  // The chain of identical cells, one quotient bit of each division per cell.
  for (genvar k = 0; k < rhc_pkg::NumCells; k++) begin : g_cell
    rhc_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[k]),
      .up_ready (link_ready[k]),
      .up_word  (link_word[k]),
      .dn_valid (link_valid[k+1]),
      .dn_ready (link_ready[k+1]),
      .dn_word  (link_word[k+1])
    );
  end

  rhc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (link_valid[rhc_pkg::NumCells]),
    .up_ready       (link_ready[rhc_pkg::NumCells]),
    .up_word        (link_word[rhc_pkg::NumCells]),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hue        (out_hue),
    .out_saturation (out_saturation),
    .out_value      (out_value)
  );

endmodule
